// ===== rtl/core/pde_pkg.sv =====
package pde_pkg;

  typedef enum logic [1:0] {
    OP_KEY      = 2'd0,
    OP_KEY_END  = 2'd1,
    OP_TEXT     = 2'd2,
    OP_TEXT_END = 2'd3
  } op_e;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_Z = 5'd25;

  localparam int ALPHA = 26;
  localparam logic [4:0] CELLS = 5'd25;
  localparam logic [2:0] SIDE_LAST = 3'd4;

  localparam logic [7:0] ASCII_A = 8'd65;
  localparam logic [7:0] ASCII_Z = 8'd90;
  localparam logic [6:0] OUT_A = 7'd65;
  localparam logic [6:0] OUT_J = 7'd74;
  localparam logic [6:0] OUT_Z = 7'd90;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef struct packed {
    op_e        op;
    logic       is_letter;
    logic [4:0] letter;
  } cmd_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

endpackage

// ===== rtl/core/playfair_digraph_encrypt.sv =====
// Playfair encryptor. Send key bytes (tuser 0), then end of key (tuser 1); the
// square is completed with the unused letters in the back end. Then send text
// bytes (tuser 2) and end of text (tuser 3). Only A-Z count, J is read as I,
// other bytes are dropped. Each finished letter pair gives one output item; a
// repeated second letter becomes X, and end of text pads a lone letter with X
// and sets tuser. A completed pair passes position lookup, square lookup and
// the output register in turn; the back end takes no new byte meanwhile or
// while it completes the square. A four-entry queue and the output register
// let input and output stall independently. A key byte after a finished
// square starts a new key.
module playfair_digraph_encrypt import pde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // ch[7:0]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // first_letter[6:0], second_letter[13:7], zero[15:14]
  output logic        m_axis_tuser_o    // padded
);

  cmd_t       cmd;
  logic       cmd_valid, cmd_ready;
  logic [6:0] first_letter, second_letter;

  pde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (s_axis_tuser_i),
    .ch_i        (s_axis_tdata_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  pde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .first_o     (first_letter),
    .second_o    (second_letter),
    .padded_o    (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, second_letter, first_letter};

endmodule

// ===== rtl/core/pde_front.sv =====
module pde_front import pde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] ch_i,
  output cmd_t       cmd_o,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i
);

  cmd_t fifo_q [QDEPTH];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QAW:0]   cnt_q, cnt_d;
  cmd_t           cmd_in;
  logic [4:0]     raw_letter;
  logic           keep, push, pop;

  always_comb begin
    raw_letter       = 5'(ch_i - ASCII_A);
    cmd_in.op        = op_e'(op_i);
    cmd_in.is_letter = (ch_i >= ASCII_A) && (ch_i <= ASCII_Z);
    cmd_in.letter    = (raw_letter == LETTER_J) ? LETTER_I : raw_letter;
  end

  // non-letter text bytes leave no trace, so they die here
  assign keep        = !((cmd_in.op == OP_TEXT) && !cmd_in.is_letter);
  assign in_ready_o  = (cnt_q != (QAW+1)'(QDEPTH));
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + QAW'(1) : wr_q;
    rd_d  = pop ? rd_q + QAW'(1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/core/pde_back.sv =====
module pde_back import pde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] first_o,
  output logic [6:0] second_o,
  output logic       padded_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FILL   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  state_e state_q, state_d;
  logic [ALPHA-1:0] used_q, used_d, used_base;
  logic [4:0] fill_q, fill_d, fill_base;
  logic [2:0] row_q, row_d, row_base;
  logic [2:0] col_q, col_d, col_base;
  logic       ready_q, ready_d;
  logic [4:0] held_q, held_d;
  logic       held_valid_q, held_valid_d;
  logic [4:0] k_q, k_d;
  logic       pad_q, pad_d;

  logic [4:0] sq_mem [CELLS];
  pos_t       pos_mem [ALPHA];

  logic       place_en, place_ok;
  logic [4:0] place_letter;
  logic       lookup_en;
  logic [4:0] la, lb;
  pos_t       pa_q, pb_q;
  logic [4:0] sx_q, sy_q;
  logic [4:0] addr_x, addr_y;

  logic       out_valid_q, emit;
  logic [6:0] first_q, second_q;
  logic       padded_q;

  always_comb begin
    state_d      = state_q;
    used_base    = used_q;
    fill_base    = fill_q;
    row_base     = row_q;
    col_base     = col_q;
    ready_d      = ready_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    k_d          = k_q;
    pad_d        = pad_q;
    place_en     = 1'b0;
    place_letter = cmd_i.letter;
    lookup_en    = 1'b0;
    la           = held_q;
    lb           = LETTER_X;
    cmd_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_KEY: begin
              // a key byte after a finished square starts a new key
              if (ready_q) begin
                used_base    = '0;
                fill_base    = '0;
                row_base     = '0;
                col_base     = '0;
                ready_d      = 1'b0;
                held_valid_d = 1'b0;
              end
              place_en = cmd_i.is_letter;
            end
            OP_KEY_END: begin
              if (!ready_q) begin
                k_d     = '0;
                state_d = ST_FILL;
              end
            end
            OP_TEXT: begin
              if (ready_q && cmd_i.is_letter) begin
                if (!held_valid_q) begin
                  held_d       = cmd_i.letter;
                  held_valid_d = 1'b1;
                end else begin
                  held_valid_d = 1'b0;
                  lookup_en    = 1'b1;
                  lb           = (cmd_i.letter == held_q) ? LETTER_X : cmd_i.letter;
                  pad_d        = 1'b0;
                  state_d      = ST_LOOKUP;
                end
              end
            end
            OP_TEXT_END: begin
              if (ready_q && held_valid_q) begin
                held_valid_d = 1'b0;
                lookup_en    = 1'b1;
                pad_d        = 1'b1;
                state_d      = ST_LOOKUP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        place_en     = (k_q != LETTER_J);
        place_letter = k_q;
        k_d          = k_q + 5'd1;
        if (k_q == LETTER_Z) begin
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LOOKUP: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    place_ok = place_en && !used_base[place_letter] && (fill_base < CELLS);
    used_d   = used_base;
    fill_d   = fill_base;
    row_d    = row_base;
    col_d    = col_base;
    if (place_ok) begin
      used_d[place_letter] = 1'b1;
      fill_d = fill_base + 5'd1;
      if (col_base == SIDE_LAST) begin
        col_d = 3'd0;
        row_d = row_base + 3'd1;
      end else begin
        col_d = col_base + 3'd1;
      end
    end
  end

  always_comb begin
    if (pa_q.row == pb_q.row) begin
      addr_x = cell_addr(pa_q.row, wrap_inc(pa_q.col));
      addr_y = cell_addr(pb_q.row, wrap_inc(pb_q.col));
    end else if (pa_q.col == pb_q.col) begin
      addr_x = cell_addr(wrap_inc(pa_q.row), pa_q.col);
      addr_y = cell_addr(wrap_inc(pb_q.row), pb_q.col);
    end else begin
      addr_x = cell_addr(pa_q.row, pb_q.col);
      addr_y = cell_addr(pb_q.row, pa_q.col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= '0;
      fill_q       <= '0;
      row_q        <= '0;
      col_q        <= '0;
      ready_q      <= 1'b0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      k_q          <= '0;
      pad_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      fill_q       <= fill_d;
      row_q        <= row_d;
      col_q        <= col_d;
      ready_q      <= ready_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      k_q          <= k_d;
      pad_q        <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_ok) begin
      sq_mem[fill_base]     <= place_letter;
      pos_mem[place_letter] <= '{row: row_base, col: col_base};
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_en) begin
      pa_q <= pos_mem[la];
      pb_q <= pos_mem[lb];
    end
    if (state_q == ST_LOOKUP) begin
      sx_q <= sq_mem[addr_x];
      sy_q <= sq_mem[addr_y];
    end
  end

  assign emit = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      first_q  <= OUT_A + {2'b00, sx_q};
      second_q <= OUT_A + {2'b00, sy_q};
      padded_q <= pad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign first_o     = first_q;
  assign second_o    = second_q;
  assign padded_o    = padded_q;

endmodule

// ===== rtl/core/pde_checker.sv =====
module pde_props import pde_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  a_first_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[6:0] >= OUT_A) && (m_axis_tdata_o[6:0] <= OUT_Z)
                        && (m_axis_tdata_o[6:0] != OUT_J))
    else $error("first letter out of square alphabet");

  a_second_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[13:7] >= OUT_A) && (m_axis_tdata_o[13:7] <= OUT_Z)
                        && (m_axis_tdata_o[13:7] != OUT_J))
    else $error("second letter out of square alphabet");

  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:14] == 2'b00))
    else $error("tdata fill bits not zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output item changed while stalled");

endmodule

bind playfair_digraph_encrypt pde_props u_pde_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== sim/pde_checker.sv =====
module pde_checker import pde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_o,
  input  logic        m_axis_tuser_o,
  output int          fails_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] first;
    logic [6:0] second;
    logic       padded;
  } digraph_t;

  logic [4:0]  key_square [25];
  logic [2:0]  row_of [26];
  logic [2:0]  col_of [26];
  logic [25:0] used_mask = '0;
  int          filled = 0;
  bit          square_done = 1'b0;
  logic [4:0]  held = '0;
  bit          held_ok = 1'b0;

  digraph_t digraph_q[$];
  int       mismatches = 0;
  int       waiting = 0;

  assign fails_o   = mismatches;
  assign pending_o = waiting;

  function automatic bit letter_of(input logic [7:0] ch, output logic [4:0] idx);
    idx = '0;
    if (ch < ASCII_A || ch > ASCII_Z) return 1'b0;
    idx = 5'(ch - ASCII_A);
    if (idx == LETTER_J) idx = LETTER_I;
    return 1'b1;
  endfunction

  function automatic void place_letter(input logic [4:0] idx);
    if (used_mask[idx] || filled >= int'(CELLS)) return;
    key_square[filled] = idx;
    row_of[idx] = 3'(filled / 5);
    col_of[idx] = 3'(filled % 5);
    used_mask[idx] = 1'b1;
    filled++;
  endfunction

  function automatic digraph_t cipher_pair(input logic [4:0] a, input logic [4:0] b,
                                           input logic pad);
    logic [4:0] b2;
    logic [4:0] x;
    logic [4:0] y;
    int ra, ca, rb, cb;
    digraph_t d;
    b2 = (a == b) ? LETTER_X : b;
    ra = row_of[a];
    ca = col_of[a];
    rb = row_of[b2];
    cb = col_of[b2];
    if (ra == rb) begin
      x = key_square[ra * 5 + (ca + 1) % 5];
      y = key_square[rb * 5 + (cb + 1) % 5];
    end else if (ca == cb) begin
      x = key_square[((ra + 1) % 5) * 5 + ca];
      y = key_square[((rb + 1) % 5) * 5 + cb];
    end else begin
      x = key_square[ra * 5 + cb];
      y = key_square[rb * 5 + ca];
    end
    d.first  = OUT_A + 7'(x);
    d.second = OUT_A + 7'(y);
    d.padded = pad;
    return d;
  endfunction

  function automatic void absorb_item(input op_e op, input logic [7:0] ch);
    logic [4:0] idx;
    bit ok;
    ok = letter_of(ch, idx);
    case (op)
      OP_KEY: begin
        // a key byte after a finished square starts over
        if (square_done) begin
          used_mask   = '0;
          filled      = 0;
          square_done = 1'b0;
          held_ok     = 1'b0;
        end
        if (ok) place_letter(idx);
      end
      OP_KEY_END: begin
        if (!square_done) begin
          for (int k = 0; k < ALPHA; k++) begin
            if (5'(k) != LETTER_J) place_letter(5'(k));
          end
          square_done = 1'b1;
        end
      end
      OP_TEXT: begin
        if (square_done && ok) begin
          if (!held_ok) begin
            held    = idx;
            held_ok = 1'b1;
          end else begin
            held_ok = 1'b0;
            digraph_q = {digraph_q, cipher_pair(held, idx, 1'b0)};
          end
        end
      end
      default: begin
        if (square_done && held_ok) begin
          held_ok = 1'b0;
          digraph_q = {digraph_q, cipher_pair(held, LETTER_X, 1'b1)};
        end
      end
    endcase
  endfunction

  function automatic void check_digraph(input digraph_t got);
    digraph_t want;
    if (digraph_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected digraph %c%c padded %0b", got.first, got.second, got.padded);
      return;
    end
    want = digraph_q.pop_front();
    if (got.first != want.first || got.second != want.second || got.padded != want.padded)
    begin
      mismatches++;
      if (mismatches <= 10)
        $display("digraph mismatch: expected %c%c padded %0b, got %c%c (%0d %0d) padded %0b",
                 want.first, want.second, want.padded, got.first, got.second,
                 got.first, got.second, got.padded);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        check_digraph({m_axis_tdata_o[6:0], m_axis_tdata_o[13:7], m_axis_tuser_o});
      if (s_axis_tvalid_i && s_axis_tready_o)
        absorb_item(op_e'(s_axis_tuser_i), s_axis_tdata_i);
      waiting = digraph_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench import pde_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = OP_KEY;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  int fails;
  int pending;
  int gap_pct = 21;
  int stall_pct = 87;
  int items_sent = 0;
  int cycle_count = 0;

  always #1 clk_i = ~clk_i;

  playfair_digraph_encrypt i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  pde_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .fails_o         (fails),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_item(input op_e op, input logic [7:0] ch);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= ch;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'(ASCII_A + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic run_message();
    logic [7:0] alphabet [26];
    logic [7:0] swap;
    logic [7:0] ch;
    logic [7:0] prev_ch;
    int key_len, text_len, j;
    prev_ch = rand_letter();
    if ($urandom_range(7) == 0) begin
      // whole alphabet in shuffled order fills the square from the key alone
      for (int k = 0; k < 26; k++) alphabet[k] = 8'(ASCII_A + k);
      for (int k = 25; k > 0; k--) begin
        j = $urandom_range(k);
        swap = alphabet[k];
        alphabet[k] = alphabet[j];
        alphabet[j] = swap;
      end
      for (int k = 0; k < 26; k++) push_item(OP_KEY, alphabet[k]);
    end else begin
      key_len = $urandom_range(1, 10);
      for (int k = 0; k < key_len; k++)
        push_item(OP_KEY, ($urandom_range(99) < 85) ? rand_letter() : rand_byte());
    end
    if ($urandom_range(9) != 0) push_item(OP_KEY_END, rand_byte());
    if ($urandom_range(19) == 0) push_item(OP_KEY_END, rand_byte());
    text_len = $urandom_range(1, 30);
    for (int k = 0; k < text_len; k++) begin
      if ($urandom_range(99) < 12) ch = rand_byte();
      else if ($urandom_range(99) < 15) ch = prev_ch;
      else ch = rand_letter();
      prev_ch = ch;
      push_item(OP_TEXT, ch);
    end
    if ($urandom_range(3) != 0) push_item(OP_TEXT_END, rand_byte());
    if ($urandom_range(9) == 0) push_item(op_e'($urandom_range(3)), rand_byte());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // text before any square exists
    push_item(OP_TEXT, "A");
    push_item(OP_TEXT_END, 8'h00);
    // key with junk bytes, folded J and a repeat
    push_item(OP_KEY, 8'h00);
    push_item(OP_KEY, "Z");
    push_item(OP_KEY, "J");
    push_item(OP_KEY, "I");
    push_item(OP_KEY, "z");
    push_item(OP_KEY, 8'hFF);
    push_item(OP_KEY, "Q");
    push_item(OP_KEY_END, 8'hFF);
    push_item(OP_KEY_END, 8'h00);
    push_item(OP_TEXT_END, 8'h55);
    // double letter, dropped byte, same row, same column, J as I
    push_item(OP_TEXT, "Z");
    push_item(OP_TEXT, "Z");
    push_item(OP_TEXT, 8'h40);
    push_item(OP_TEXT, "A");
    push_item(OP_TEXT, "B");
    push_item(OP_TEXT, "Z");
    push_item(OP_TEXT, "C");
    push_item(OP_TEXT, "A");
    push_item(OP_TEXT, "M");
    push_item(OP_TEXT, "J");
    push_item(OP_TEXT, "K");
    // lone X padded with X
    push_item(OP_TEXT, "X");
    push_item(OP_TEXT_END, 8'hAA);

    while (items_sent < 150) run_message();
    gap_pct   = 87;
    stall_pct = 21;
    while (items_sent < 300) run_message();
    gap_pct   = 0;
    stall_pct = 0;
    while (items_sent < 460) run_message();
    s_axis_tvalid_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (16) @(posedge clk_i);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
